### src/tumbling_window_vector_mean_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tumbling window vector mean block
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TUMBLING_WINDOW_VECTOR_MEAN_ASSERT_SVH
`define TUMBLING_WINDOW_VECTOR_MEAN_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TWVM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TWVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define TWVM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/twvm_pkg.sv
// ----------------------------------------------------------------------------
// twvm_pkg
// Shared widths, constants and the controller command bundle.
// ----------------------------------------------------------------------------
package twvm_pkg;

    localparam int LANES     = 4;
    localparam int TIME_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 40;
    localparam int MEAN_W    = 24;
    localparam int FRAC_BITS = 8;
    localparam int WLEN_W    = 16;

    // Quotient bits produced by the restoring divider, one per step
    localparam int DIV_STEPS  = MEAN_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // Magnitude bits that enter the quotient shift register
    localparam int MAG_LO_W = MEAN_W - FRAC_BITS;
    // Magnitude bits that form the starting remainder
    localparam int MAG_HI_W = SUM_W - MAG_LO_W;

    localparam int IN_DATA_W  = TIME_W + LANES * SAMPLE_W;
    localparam int OUT_DATA_W = LANES * MEAN_W;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(3);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the input transfer
        logic update;    // window decision and lane sum update
        logic prep;      // magnitude, overflow check, divider setup
        logic step;      // one restoring division step per lane
        logic load_out;  // move the means into the output register
    } twvm_cmd_t;

endpackage

### src/twvm_ctrl.sv
// ----------------------------------------------------------------------------
// twvm_ctrl
// Sequencer for one item: capture, update, divider setup, division steps and
// handoff to the output register.
// ----------------------------------------------------------------------------
module twvm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output twvm_pkg::twvm_cmd_t cmd
);
    import twvm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_CNT_W-1:0] count_reg, count_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Decode commands from the current state
    always_comb begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.prep     = (state_reg == ST_PREP);
        cmd.step     = (state_reg == ST_DIV);
        cmd.load_out = (state_reg == ST_FINISH) && out_free;
    end

    // Next state, step count and output valid
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                count_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                count_next = count_reg + STEP_CNT_W'(1);
                if (count_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### src/twvm_datapath.sv
// ----------------------------------------------------------------------------
// twvm_datapath
// Window state, saturating lane sums, one restoring divider per lane and the
// output register.
// ----------------------------------------------------------------------------
module twvm_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  twvm_pkg::twvm_cmd_t                 cmd,
    input  logic                                cfg_wr_en,
    input  logic [twvm_pkg::WLEN_W-1:0]         cfg_wr_data,
    input  logic [twvm_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic [twvm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);
    import twvm_pkg::*;

    localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    // Window state and configuration
    logic                       started_reg;
    logic [TIME_W-1:0]          mark_reg;
    logic [WLEN_W-1:0]          wlen_reg;
    logic                       open_reg;
    logic [WLEN_W-1:0]          div_reg;

    // Captured input
    logic [TIME_W-1:0]          time_reg;
    logic signed [SAMPLE_W-1:0] samp_reg [LANES];

    // Per-lane sums and divider state
    logic signed [SUM_W-1:0]    sum_reg  [LANES];
    logic                       neg_reg  [LANES];
    logic                       ovf_reg  [LANES];
    logic [WLEN_W-1:0]          rem_reg  [LANES];
    logic [MEAN_W-1:0]          quo_reg  [LANES];

    logic [OUT_DATA_W-1:0]      m_tdata_reg;
    logic                       m_tuser_reg;

    logic [TIME_W-1:0]          span;
    logic                       open_now;
    logic [WLEN_W-1:0]          div_now;

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // Window decision from the distance to the mark
    always_comb begin
        span     = time_reg - mark_reg;
        open_now = !started_reg || (span > TIME_W'(wlen_reg));
        if (open_now || (span[WLEN_W-1:0] == '0)) begin
            div_now = WLEN_W'(1);
        end else begin
            div_now = span[WLEN_W-1:0];
        end
    end

    // Configuration and window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg    <= WLEN_RESET;
            started_reg <= 1'b0;
            mark_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            if (cmd.update && open_now) begin
                started_reg <= 1'b1;
                mark_reg    <= time_reg - TIME_W'(1);
            end
        end
    end

    // Capture the input transfer and the window decision
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            time_reg <= s_tdata[TIME_W-1:0];
        end
        if (cmd.update) begin
            open_reg <= open_now;
            div_reg  <= div_now;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [SUM_W:0]     sum_wide;
        logic signed [SUM_W-1:0]   sum_sat;
        logic [SUM_W-1:0]          mag;
        logic [MAG_HI_W-1:0]       mag_hi;
        logic [WLEN_W:0]           trial;
        logic                      ge;
        logic [MEAN_W-1:0]         mean;

        // Saturating accumulate
        always_comb begin
            sum_wide = (SUM_W+1)'(sum_reg[l]) + (SUM_W+1)'(samp_reg[l]);
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sum_sat = sum_wide[SUM_W-1:0];
            end
        end

        // Magnitude of the sum; the most negative sum maps to 2^(SUM_W-1)
        always_comb begin
            mag    = sum_reg[l][SUM_W-1] ? (~sum_reg[l] + SUM_W'(1)) : sum_reg[l];
            mag_hi = mag[SUM_W-1:MAG_LO_W];
        end

        // One restoring division step
        always_comb begin
            trial = {rem_reg[l], quo_reg[l][MEAN_W-1]};
            ge    = (trial >= {1'b0, div_reg});
        end

        // Apply sign and clamp to the mean range
        always_comb begin
            if (ovf_reg[l]) begin
                mean = neg_reg[l] ? MEAN_MIN : MEAN_MAX;
            end else if (neg_reg[l]) begin
                mean = (quo_reg[l] > MEAN_MIN) ? MEAN_MIN : (~quo_reg[l] + MEAN_W'(1));
            end else begin
                mean = (quo_reg[l] > MEAN_MAX) ? MEAN_MAX : quo_reg[l];
            end
        end

        // Lane sum, reset to zero
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sum_reg[l] <= '0;
            end else if (cmd.update) begin
                sum_reg[l] <= open_now ? SUM_W'(samp_reg[l]) : sum_sat;
            end
        end

        // Sample capture and divider registers
        always_ff @(posedge aclk) begin
            if (cmd.load_in) begin
                samp_reg[l] <= s_tdata[TIME_W + l*SAMPLE_W +: SAMPLE_W];
            end
            if (cmd.prep) begin
                neg_reg[l] <= sum_reg[l][SUM_W-1];
                ovf_reg[l] <= (mag_hi >= MAG_HI_W'(div_reg));
                rem_reg[l] <= mag_hi[WLEN_W-1:0];
                quo_reg[l] <= {mag[MAG_LO_W-1:0], {FRAC_BITS{1'b0}}};
            end else if (cmd.step) begin
                rem_reg[l] <= ge ? WLEN_W'(trial - {1'b0, div_reg}) : trial[WLEN_W-1:0];
                quo_reg[l] <= {quo_reg[l][MEAN_W-2:0], ge};
            end
            if (cmd.load_out) begin
                m_tdata_reg[l*MEAN_W +: MEAN_W] <= mean;
            end
        end
    end

    // Window flag travels with the means
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tuser_reg <= open_reg;
        end
    end

endmodule

### src/tumbling_window_vector_mean.sv
// ----------------------------------------------------------------------------
// tumbling_window_vector_mean
// Running mean per lane over a tumbling time window, Q16.8 results.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer carries a time stamp and four signed samples.
// Output stream m_*: one transfer per input carries four Q16.8 lane means in
// m_tdata and, in m_tuser, a flag that is set when that input opened a window.
// cfg_wr_en / cfg_wr_data write the window length; write only while idle.
// Each item passes through capture, window update, divider setup, the 24
// steps of the per-lane restoring divider and handoff to the output
// register; the next item is taken only after that handoff. s_tready is
// high again in the cycle the result appears, so the next item is taken
// while a result waits in the output register.
// If the receiver stalls, the result holds in the output register; the next
// item is still taken and worked on, then waits until the register is free.
// Reset clears the window state, the lane sums and the output valid and sets
// the window length to 3; the first item after reset always opens a window.
// ----------------------------------------------------------------------------
module tumbling_window_vector_mean (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [twvm_pkg::WLEN_W-1:0]         cfg_wr_data,  // window_length
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // time_stamp, sample_0, sample_1, sample_2, sample_3
    input  logic [twvm_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mean_0, mean_1, mean_2, mean_3
    output logic [twvm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser       // window_opened
);
    import twvm_pkg::*;

    twvm_cmd_t cmd;

    // Item sequencer
    twvm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Sums, dividers and output register
    twvm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### src/twvm_checker.sv
// ----------------------------------------------------------------------------
// twvm_checker
// Port-level checks for the tumbling window vector mean block.
// ----------------------------------------------------------------------------
`include "tumbling_window_vector_mean_assert.svh"

module twvm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [twvm_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                m_tuser
);

    // Stalled result holds
    `TWVM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // One item at a time: input closes after a transfer
    `TWVM_ASSERT_NEXT(a_in_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input open right after transfer")

    // A new result comes with the input reopening
    `TWVM_ASSERT_IMPLY(a_result_idle, aclk, aresetn, $rose(m_tvalid), s_tready, "result without return to idle")

    // Reset empties the output and opens the input
    `TWVM_ASSERT_NEXT_ALWAYS(a_reset, aclk, !aresetn, !m_tvalid && s_tready, "bad state after reset")

endmodule

bind tumbling_window_vector_mean twvm_checker u_checker (.*);

### bench/tumbling_window_vector_mean_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tumbling_window_vector_mean_check
// Watches both streams and the window length port of the block. For every
// accepted input transfer it works out the four lane means and the window
// flag, then compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tumbling_window_vector_mean_check
    import twvm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [WLEN_W-1:0]     cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    fail_count,
    output int                    pending
);

    localparam int QUO_W = SUM_W + FRAC_BITS;

    localparam logic signed [SUM_W-1:0] SUM_TOP    = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_BOTTOM = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] POS_MEAN_LIMIT = (QUO_W'(1) << (MEAN_W - 1)) - 1;
    localparam logic [QUO_W-1:0] NEG_MEAN_LIMIT = QUO_W'(1) << (MEAN_W - 1);

    typedef struct packed {
        logic [LANES-1:0][MEAN_W-1:0] means;
        logic                         opened;
    } lane_means_t;

    // Window state mirrored from the block
    logic                    window_live;
    logic [TIME_W-1:0]       window_mark;
    logic signed [SUM_W-1:0] lane_sum [LANES];
    logic [WLEN_W-1:0]       window_len;

    lane_means_t expected_means [$];

    // Add one sample to a lane sum, clamping at the 40-bit signed range
    function automatic logic signed [SUM_W-1:0] add_clamped(
        input logic signed [SUM_W-1:0]    acc,
        input logic signed [SAMPLE_W-1:0] x
    );
        logic signed [SUM_W:0] wide;
        wide = acc + x;
        if (wide > SUM_TOP) begin
            return SUM_TOP;
        end
        if (wide < SUM_BOTTOM) begin
            return SUM_BOTTOM;
        end
        return wide[SUM_W-1:0];
    endfunction

    // Q16.8 mean truncated toward zero, clamped to the 24-bit signed range
    function automatic logic [MEAN_W-1:0] lane_mean(
        input logic signed [SUM_W-1:0] acc,
        input logic [TIME_W-1:0]       span
    );
        logic [SUM_W-1:0]  mag;
        logic [QUO_W-1:0]  quo;
        logic [TIME_W-1:0] divisor;
        divisor = (span == '0) ? TIME_W'(1) : span;
        mag = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
        quo = {mag, {FRAC_BITS{1'b0}}} / QUO_W'(divisor);
        if (acc[SUM_W-1]) begin
            if (quo > NEG_MEAN_LIMIT) begin
                quo = NEG_MEAN_LIMIT;
            end
            quo = -quo;
            return quo[MEAN_W-1:0];
        end
        if (quo > POS_MEAN_LIMIT) begin
            quo = POS_MEAN_LIMIT;
        end
        return quo[MEAN_W-1:0];
    endfunction

    always @(posedge aclk) begin
        lane_means_t             got;
        lane_means_t             want;
        logic [TIME_W-1:0]       stamp;
        logic [TIME_W-1:0]       span;
        logic                    opens;
        logic signed [SAMPLE_W-1:0] x;
        if (!aresetn) begin
            window_live = 1'b0;
            window_mark = '0;
            for (int i = 0; i < LANES; i++) begin
                lane_sum[i] = '0;
            end
            window_len = WLEN_RESET;
            expected_means.delete();
            fail_count = 0;
        end else begin
            // Take a new window length
            if (cfg_wr_en) begin
                window_len = cfg_wr_data;
            end

            // Compare an output transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.means  = m_tdata;
                got.opened = m_tuser;
                if (expected_means.size() == 0) begin
                    $error("output transfer with no prediction waiting");
                    fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    for (int i = 0; i < LANES; i++) begin
                        if (got.means[i] !== want.means[i]) begin
                            $error("mean_%0d: expected %0d, actual %0d", i,
                                   $signed(want.means[i]), $signed(got.means[i]));
                            fail_count++;
                        end
                    end
                    if (got.opened !== want.opened) begin
                        $error("window_opened: expected %0d, actual %0d",
                               want.opened, got.opened);
                        fail_count++;
                    end
                end
            end

            // Predict the result of an input transfer
            if (s_tvalid && s_tready) begin
                stamp = s_tdata[TIME_W-1:0];
                span  = stamp - window_mark;
                opens = !window_live || (span > TIME_W'(window_len));
                if (opens) begin
                    window_live = 1'b1;
                    window_mark = stamp - 1;
                    span        = TIME_W'(1);
                end
                for (int i = 0; i < LANES; i++) begin
                    x = s_tdata[TIME_W + i*SAMPLE_W +: SAMPLE_W];
                    lane_sum[i] = opens ? SUM_W'(x) : add_clamped(lane_sum[i], x);
                    want.means[i] = lane_mean(lane_sum[i], span);
                end
                want.opened = opens;
                expected_means.push_back(want);
            end
        end
        pending = expected_means.size();
    end

endmodule

### bench/tumbling_window_vector_mean_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tumbling_window_vector_mean_test
// Drives time stamped four-lane samples into the block through a bursty
// sender and drains the means through a receiver that stalls on its own
// pattern. A short directed run covers the saturation, zero span, wraparound
// and window length corners; random phases then sweep several window lengths.
// ----------------------------------------------------------------------------
module tumbling_window_vector_mean_test;
    import twvm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 60;   // longer than the block latency
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES          = 9;

    typedef logic [LANES-1:0][SAMPLE_W-1:0] lane_samples_t;
    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_HOLD} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [WLEN_W-1:0]     cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // Sender state
    int                burst_left;
    int                surge_left;
    logic [LANES-1:0]  surge_signs;
    logic [TIME_W-1:0] now_stamp;
    logic [WLEN_W-1:0] cur_window;

    tumbling_window_vector_mean uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    tumbling_window_vector_mean_check mean_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Stall the receiver in stretches: always ready, choppy, or mostly held
    initial begin
        rx_mode_t mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 2));
                left = $urandom_range(5, 80);
            end
            left--;
            case (mode)
                RX_OPEN: begin
                    m_tready <= 1'b1;
                end
                RX_CHOPPY: begin
                    m_tready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 9) == 0);
                end
            endcase
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic lane_samples_t lanes_of(
        input logic [SAMPLE_W-1:0] s0,
        input logic [SAMPLE_W-1:0] s1,
        input logic [SAMPLE_W-1:0] s2,
        input logic [SAMPLE_W-1:0] s3
    );
        return {s3, s2, s1, s0};
    endfunction

    // Mix extremes, values near zero and full-range noise
    function automatic lane_samples_t random_lanes();
        lane_samples_t lanes;
        for (int i = 0; i < LANES; i++) begin
            case ($urandom_range(0, 7))
                0: lanes[i] = 16'h7FFF;
                1: lanes[i] = 16'h8000;
                2: lanes[i] = SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
                default: lanes[i] = SAMPLE_W'($urandom);
            endcase
        end
        return lanes;
    endfunction

    // Offer one sample set and hold it until the transfer; then maybe pause
    task automatic send_samples(input logic [TIME_W-1:0] stamp, input lane_samples_t lanes);
        s_tdata  <= {lanes, stamp};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
        end
    endtask

    // Drop valid and wait until every predicted mean has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic set_window(input logic [WLEN_W-1:0] len);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_window  = len;
    endtask

    // Mostly advance the stamp inside the window; sometimes jump or step back
    task automatic send_random_samples();
        logic [TIME_W-1:0] step;
        lane_samples_t     lanes;
        if (surge_left == 0 && $urandom_range(0, 39) == 0) begin
            surge_left  = $urandom_range(2, 6);
            surge_signs = LANES'($urandom);
        end
        if (surge_left > 0) begin
            // Pile extremes onto one stamp to push the means past full scale
            surge_left--;
            for (int i = 0; i < LANES; i++) begin
                lanes[i] = surge_signs[i] ? 16'h8000 : 16'h7FFF;
            end
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: begin
                    step = '0;
                end
                5, 6, 7, 8, 9, 10: begin
                    step = $urandom_range(1, (cur_window > 8) ? 8 : cur_window + 1);
                end
                11, 12: begin
                    step = $urandom_range(0, cur_window);
                end
                13: begin
                    step = TIME_W'(cur_window) + 1;
                end
                14: begin
                    step = $urandom;
                end
                default: begin
                    step = TIME_W'(0) - TIME_W'($urandom_range(1, 3));
                end
            endcase
            now_stamp = now_stamp + step;
            lanes = random_lanes();
        end
        send_samples(now_stamp, lanes);
    endtask

    initial begin
        logic [WLEN_W-1:0] len;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        burst_left  = 0;
        surge_left  = 0;
        surge_signs = '0;
        now_stamp   = '0;
        cur_window  = WLEN_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default window of 3: first item, mean saturation both ways, window edge
        send_samples(32'h0000_0000, lanes_of(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
        send_samples(32'h0000_0000, lanes_of(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
        send_samples(32'h0000_0001, lanes_of(16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000));
        send_samples(32'h0000_0002, lanes_of(16'h1234, 16'hEDCB, 16'h8000, 16'h7FFF));
        send_samples(32'h0000_0003, lanes_of(16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF));
        // Stamp back onto the mark: zero span
        send_samples(32'h0000_0002, lanes_of(16'h8000, 16'h7FFF, 16'hFFFE, 16'h0002));
        // Far jump, then wrap the stamp through zero
        send_samples(32'hFFFF_FFF0, random_lanes());
        send_samples(32'hFFFF_FFFF, random_lanes());
        send_samples(32'h0000_0000, random_lanes());
        send_samples(32'h0000_0001, random_lanes());

        // Zero window: any nonzero span opens, the mark itself does not
        set_window(16'd0);
        send_samples(32'h0000_000A, lanes_of(16'h7FFF, 16'h8000, 16'h0100, 16'hFF00));
        send_samples(32'h0000_000A, lanes_of(16'h7FFF, 16'h8000, 16'h0100, 16'hFF00));
        send_samples(32'h0000_0009, lanes_of(16'h7FFF, 16'h8000, 16'h0100, 16'hFF00));

        // Widest window: last span inside, first span outside
        set_window(16'hFFFF);
        send_samples(32'h8000_0000, lanes_of(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_samples(32'h8000_FFFE, lanes_of(16'h8000, 16'h7FFF, 16'h0003, 16'hFFFD));
        send_samples(32'h8000_FFFF, lanes_of(16'h7FFF, 16'h8000, 16'hC000, 16'h4000));
        send_samples(32'h8001_0000, random_lanes());
        now_stamp = 32'h8001_0000;

        // Random phases over a spread of window lengths
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: len = 16'd3;
                1: len = 16'd1;
                2: len = 16'd0;
                3: len = 16'hFFFF;
                4: len = 16'd2;
                5: len = 16'd16;
                6: len = 16'd255;
                default: len = WLEN_W'($urandom_range(1, 65535));
            endcase
            set_window(len);
            repeat (ITEMS_PER_PHASE) send_random_samples();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
